// ----- rtl/asg_pkg.sv -----
// ----------------------------------------------------------------------------
// asg_pkg: shared types and constants of the arrow segment generator
// Coordinate format, rotation constants, queue entry and sequencer states.
// ----------------------------------------------------------------------------
package asg_pkg;

  // fraction bits of the coordinate format
  localparam int FRAC_BITS = 16;

  // clamp limits of the raw vector length
  localparam logic [33:0] LEN_LO = 34'(30) << FRAC_BITS;
  localparam logic [33:0] LEN_HI = 34'(200) << FRAC_BITS;

  // cos and sin of 144 degrees in Q2.30
  localparam logic signed [32:0] COS144 = -33'sd868675383;
  localparam logic signed [32:0] SIN144 = 33'sd631129609;

  // reciprocal of ten, exact quotient for 32-bit dividends after the shift
  localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam logic [31:0] COLOR_RESET = 32'd255;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QADDR  = $clog2(QDEPTH);

  // classified vector as it travels through the queue
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               sh;
    logic               zero;
  } vec_t;

  // queue status seen by both sides
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QADDR:0]   count;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQX,
    BK_SQY,
    BK_SQSUM,
    BK_SQRT,
    BK_CLAMP,
    BK_DIVW,
    BK_MULN,
    BK_MULN_WR,
    BK_NUM,
    BK_DIVU,
    BK_DIVU_WAIT,
    BK_MULW,
    BK_RND,
    BK_ADD,
    BK_DONE
  } back_state_t;

endpackage

// ----- rtl/arrow_segment_generator.sv -----
// ----------------------------------------------------------------------------
// arrow_segment_generator: vector to arrow line segments
// Each vector gives a shaft and two arrowhead wings, tagged with a colour.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  input    | push / full        | start_x start_y end_x end_y
//  result   | empty / pop        | seg_x0 seg_y0 seg_x1 seg_y1 seg_color
//           |                    | last_segment
//  config   | cfg_write          | cfg_data (line colour)
//
// In the back sequencer a vector goes through a 32-step square root, four
// passes of the shared 64-step divider, and the shared multiplier.
// It yields three result transfers, the last with last_segment high.
// The front stage and a two-entry queue keep taking vectors while the back is
// busy; the back keeps working while results wait to be popped.
// Synchronous active-high reset empties the queue and output buffer and sets
// the colour to 255.
// ----------------------------------------------------------------------------
module arrow_segment_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] seg_x0,
  output logic signed [31:0] seg_y0,
  output logic signed [31:0] seg_x1,
  output logic signed [31:0] seg_y1,
  output logic [31:0]        seg_color,
  output logic               last_segment,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data
);
  import asg_pkg::*;

  logic     [31:0] line_color;
  q_stat_t         q_stat;
  logic            q_push;
  logic            q_pop;
  vec_t            q_wdata;
  vec_t            q_rdata;

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_color <= COLOR_RESET;
    end else if (cfg_write) begin
      line_color <= cfg_data;
    end
  end

  assign seg_color = line_color;

  asg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  asg_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  asg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .seg_x0       (seg_x0),
    .seg_y0       (seg_y0),
    .seg_x1       (seg_x1),
    .seg_y1       (seg_y1),
    .last_segment (last_segment)
  );

  // queue fill level moves by at most one per cycle
  a_q_step: assert property (@(posedge clk) disable iff (rst)
    (q_stat.count != $past(q_stat.count)) |->
      (q_stat.count == $past(q_stat.count) + 1'b1 ||
       q_stat.count + 1'b1 == $past(q_stat.count)))
    else $error("queue level jumped");

  // front never writes a full queue
  a_q_wr: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("write into full queue");

  // a right wing transfer is followed by a shaft or nothing
  a_last: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_segment) |=> (empty || !last_segment))
    else $error("segment order broken");

endmodule

// ----- rtl/asg_front.sv -----
// ----------------------------------------------------------------------------
// asg_front: input stage
// Takes a vector, forms the difference, scales it into 32 bits and flags a
// zero-length vector, then hands it to the queue.
// ----------------------------------------------------------------------------
module asg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [31:0]    start_x,
  input  logic signed [31:0]    start_y,
  input  logic signed [31:0]    end_x,
  input  logic signed [31:0]    end_y,
  input  asg_pkg::q_stat_t      q_stat,
  output logic                  q_push,
  output asg_pkg::vec_t         q_wdata
);
  import asg_pkg::*;

  logic               valid;
  vec_t               stage;
  logic               accept;
  logic signed [32:0] dx_w;
  logic signed [32:0] dy_w;
  logic [32:0]        ax_w;
  logic [32:0]        ay_w;
  logic               sh_w;

  assign full    = valid && q_stat.full;
  assign accept  = push && !full;
  assign q_push  = valid && !q_stat.full;
  assign q_wdata = stage;

  // exact differences and the scaling decision
  always_comb begin
    dx_w = 33'(end_x) - 33'(start_x);
    dy_w = 33'(end_y) - 33'(start_y);
    ax_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
    ay_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
    sh_w = ax_w[32] || ax_w[31] || ay_w[32] || ay_w[31];
  end

  // stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stage.sx   <= start_x;
      stage.sy   <= start_y;
      stage.ex   <= end_x;
      stage.ey   <= end_y;
      stage.dx   <= sh_w ? dx_w[32:1] : dx_w[31:0];
      stage.dy   <= sh_w ? dy_w[32:1] : dy_w[31:0];
      stage.sh   <= sh_w;
      stage.zero <= (dx_w == '0) && (dy_w == '0);
    end
  end

endmodule

// ----- rtl/asg_fifo.sv -----
// ----------------------------------------------------------------------------
// asg_fifo: short queue between front and back
// Register-based queue of classified vectors.
// ----------------------------------------------------------------------------
module asg_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  asg_pkg::vec_t     wdata,
  input  logic              rd,
  output asg_pkg::vec_t     rdata,
  output asg_pkg::q_stat_t  stat
);
  import asg_pkg::*;

  vec_t              mem [QDEPTH];
  logic [QADDR-1:0]  wp;
  logic [QADDR-1:0]  rp;
  logic [QADDR:0]    count;

  assign rdata      = mem[rp];
  assign stat.count = count;
  assign stat.full  = (count == (QADDR+1)'(QDEPTH));
  assign stat.empty = (count == '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == QADDR'(QDEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == QADDR'(QDEPTH-1)) ? '0 : rp + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

// ----- rtl/asg_div.sv -----
// ----------------------------------------------------------------------------
// asg_div: iterative unsigned divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] q;
  logic [31:0] d;
  logic [32:0] rem_sh;
  logic        ge;

  assign quo = q;

  // one restoring step
  always_comb begin
    rem_sh = {rem, q[63]};
    ge     = rem_sh >= {1'b0, d};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      d   <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, d}) : rem_sh[31:0];
      q   <= {q[62:0], ge};
    end
  end

endmodule

// ----- rtl/asg_back.sv -----
// ----------------------------------------------------------------------------
// asg_back: wing sequencer and segment output
// Works one vector at a time through square root, shared divider and
// shared multiplier, then holds the three segments for transfer.
// ----------------------------------------------------------------------------
module asg_back (
  input  logic                clk,
  input  logic                rst,
  input  asg_pkg::q_stat_t    q_stat,
  input  asg_pkg::vec_t       q_rdata,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  seg_x0,
  output logic signed [31:0]  seg_y0,
  output logic signed [31:0]  seg_x1,
  output logic signed [31:0]  seg_y1,
  output logic                last_segment
);
  import asg_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  vec_t               cur;
  logic signed [65:0] prod;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [63:0]        acc;
  logic [63:0]        sq_n;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [31:0]        len_r;
  logic [31:0]        w_r;
  logic signed [63:0] p_r [4];
  logic signed [63:0] num_r [4];
  logic [1:0]         k;
  logic signed [32:0] unit_r;
  logic               neg_r;
  logic signed [34:0] wing_r;
  logic signed [31:0] win [4];

  logic               div_start;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic [63:0]        div_quo;

  logic [31:0]        ax;
  logic [31:0]        ay;
  logic signed [32:0] dxe;
  logic signed [32:0] dye;
  logic [31:0]        lene;
  logic [63:0]        sq_try;
  logic [32:0]        raw;
  logic [33:0]        clamped;
  logic [63:0]        num_mag;
  logic [65:0]        prod_mag;
  logic [33:0]        rq;
  logic signed [35:0] sum;
  logic signed [31:0] base;

  // output buffer
  logic               out_valid;
  logic [1:0]         seg_idx;
  logic signed [31:0] o_sx;
  logic signed [31:0] o_sy;
  logic signed [31:0] o_ex;
  logic signed [31:0] o_ey;
  logic signed [31:0] o_w [4];

  asg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // operand conditioning
  always_comb begin
    ax      = cur.dx[31] ? 32'(-cur.dx) : 32'(cur.dx);
    ay      = cur.dy[31] ? 32'(-cur.dy) : 32'(cur.dy);
    dxe     = cur.zero ? 33'sd1 : 33'(cur.dx);
    dye     = cur.zero ? 33'sd0 : 33'(cur.dy);
    lene    = cur.zero ? 32'd1 : len_r;
    sq_try  = sq_res + sq_bit;
    raw     = cur.sh ? {len_r, 1'b0} : {1'b0, len_r};
    if ({1'b0, raw} < LEN_LO) begin
      clamped = LEN_LO;
    end else if ({1'b0, raw} > LEN_HI) begin
      clamped = LEN_HI;
    end else begin
      clamped = {1'b0, raw};
    end
    num_mag  = num_r[k][63] ? 64'(-num_r[k]) : 64'(num_r[k]);
    prod_mag = prod[65] ? 66'(-prod) : 66'(prod);
    rq       = 34'((prod_mag[63:0] + (64'd1 << 29)) >> 30);
    base     = k[0] ? cur.ey : cur.ex;
    sum      = 36'(base) + 36'(wing_r);
  end

  // next state and control outputs
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop      = 1'b1;
          state_next = BK_SQX;
        end
      end
      BK_SQX: begin
        mul_a      = {1'b0, ax};
        mul_b      = {1'b0, ax};
        state_next = BK_SQY;
      end
      BK_SQY: begin
        mul_a      = {1'b0, ay};
        mul_b      = {1'b0, ay};
        state_next = BK_SQSUM;
      end
      BK_SQSUM: state_next = BK_SQRT;
      BK_SQRT: begin
        if (sq_bit == '0) begin
          state_next = BK_CLAMP;
        end
      end
      // wing length by reciprocal product with one tenth
      BK_CLAMP: begin
        mul_a      = {1'b0, RECIP10};
        mul_b      = 33'(clamped + 34'd5);
        state_next = BK_DIVW;
      end
      BK_DIVW: state_next = BK_MULN;
      BK_MULN: begin
        unique case (k)
          2'd0: begin mul_a = COS144; mul_b = dxe; end
          2'd1: begin mul_a = SIN144; mul_b = dye; end
          2'd2: begin mul_a = COS144; mul_b = dye; end
          2'd3: begin mul_a = SIN144; mul_b = dxe; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        state_next = BK_MULN_WR;
      end
      BK_MULN_WR: state_next = (k == 2'd3) ? BK_NUM : BK_MULN;
      BK_NUM: state_next = BK_DIVU;
      BK_DIVU: begin
        div_start  = 1'b1;
        div_num    = num_mag + 64'(lene >> 1);
        div_den    = lene;
        state_next = BK_DIVU_WAIT;
      end
      BK_DIVU_WAIT: begin
        if (div_done) begin
          state_next = BK_MULW;
        end
      end
      BK_MULW: begin
        mul_a      = unit_r;
        mul_b      = {1'b0, w_r};
        state_next = BK_RND;
      end
      BK_RND: state_next = BK_ADD;
      BK_ADD: state_next = (k == 2'd3) ? BK_DONE : BK_DIVU;
      BK_DONE: begin
        if (!out_valid) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          cur <= q_rdata;
        end
      end
      BK_SQY: acc <= prod[63:0];
      BK_SQSUM: begin
        sq_n   <= acc + prod[63:0];
        sq_res <= '0;
        sq_bit <= 64'd1 << 62;
      end
      BK_SQRT: begin
        if (sq_bit != '0) begin
          if (sq_n >= sq_try) begin
            sq_n   <= sq_n - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end else begin
          len_r <= sq_res[31:0];
        end
      end
      BK_DIVW: begin
        w_r <= 32'(prod[63:RECIP10_SHIFT]);
        k   <= 2'd0;
      end
      BK_MULN_WR: begin
        p_r[k] <= prod[63:0];
        k      <= k + 1'b1;
      end
      BK_NUM: begin
        num_r[0] <= p_r[0] + p_r[1];
        num_r[1] <= p_r[2] - p_r[3];
        num_r[2] <= p_r[0] - p_r[1];
        num_r[3] <= p_r[2] + p_r[3];
        k        <= 2'd0;
      end
      BK_DIVU: neg_r <= num_r[k][63];
      BK_DIVU_WAIT: begin
        if (div_done) begin
          unit_r <= neg_r ? -$signed({1'b0, div_quo[31:0]}) : $signed({1'b0, div_quo[31:0]});
        end
      end
      BK_RND: begin
        wing_r <= prod[65] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
      end
      BK_ADD: begin
        if (sum > 36'sd2147483647) begin
          win[k] <= 32'sh7fffffff;
        end else if (sum < -36'sd2147483648) begin
          win[k] <= 32'sh80000000;
        end else begin
          win[k] <= sum[31:0];
        end
        k <= k + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seg_idx   <= '0;
    end else if (state == BK_DONE && !out_valid) begin
      out_valid <= 1'b1;
      seg_idx   <= '0;
    end else if (pop && out_valid) begin
      if (seg_idx == 2'd2) begin
        out_valid <= 1'b0;
        seg_idx   <= '0;
      end else begin
        seg_idx <= seg_idx + 1'b1;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (state == BK_DONE && !out_valid) begin
      o_sx <= cur.sx;
      o_sy <= cur.sy;
      o_ex <= cur.ex;
      o_ey <= cur.ey;
      for (int i = 0; i < 4; i++) begin
        o_w[i] <= win[i];
      end
    end
  end

  // segment select: shaft, left wing, right wing
  assign empty = !out_valid;
  always_comb begin
    unique case (seg_idx)
      2'd0: begin
        seg_x0 = o_sx; seg_y0 = o_sy; seg_x1 = o_ex; seg_y1 = o_ey;
        last_segment = 1'b0;
      end
      2'd1: begin
        seg_x0 = o_ex; seg_y0 = o_ey; seg_x1 = o_w[0]; seg_y1 = o_w[1];
        last_segment = 1'b0;
      end
      default: begin
        seg_x0 = o_ex; seg_y0 = o_ey; seg_x1 = o_w[2]; seg_y1 = o_w[3];
        last_segment = 1'b1;
      end
    endcase
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for the arrow segment generator
// Vectors are pushed with random gaps, segments popped with random stalls;
// each segment is compared field by field with a predicted arrow.
// ----------------------------------------------------------------------------
module tb_top;
  import asg_pkg::*;

  localparam longint COS_Q30   = -64'sd868675383;
  localparam longint SIN_Q30   = 64'sd631129609;
  localparam int     CYC_LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [31:0]        color;
    logic               last;
  } segment_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic empty;
  logic pop;
  logic signed [31:0] seg_x0, seg_y0, seg_x1, seg_y1;
  logic [31:0] seg_color;
  logic last_segment;
  logic cfg_write;
  logic [31:0] cfg_data;

  segment_t pending_segs[$];
  logic [31:0] colour_model;
  int mismatches;
  int seg_count;
  int vec_count;
  int cycles;
  int hold_off;
  int rx_gap;
  bit allow_stall;

  arrow_segment_generator u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .empty(empty), .pop(pop),
    .seg_x0(seg_x0), .seg_y0(seg_y0), .seg_x1(seg_x1), .seg_y1(seg_y1),
    .seg_color(seg_color), .last_segment(last_segment),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("arrow_segment_generator regression: fail");
      $finish;
    end
  end

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // divide rounding to nearest, halves away from zero
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // predict the three segments of one arrow
  task automatic predict_arrow(logic signed [31:0] sx, logic signed [31:0] sy,
                               logic signed [31:0] ex, logic signed [31:0] ey);
    longint dx, dy, lux, luy, rux, ruy;
    longint unsigned ax, ay, len, raw, wing;
    bit shifted;
    segment_t s;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    shifted = 0;
    if (ax >= 64'h80000000 || ay >= 64'h80000000) begin
      shifted = 1;
      dx = dx >>> 1;
      dy = dy >>> 1;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
    end
    len = floor_sqrt(ax * ax + ay * ay);
    raw = len << shifted;
    if (raw < (64'd30 << FRAC_BITS)) raw = 64'd30 << FRAC_BITS;
    else if (raw > (64'd200 << FRAC_BITS)) raw = 64'd200 << FRAC_BITS;
    wing = (raw + 5) / 10;
    // zero length points along +x
    if (len == 0) begin
      dx = 1;
      dy = 0;
      len = 1;
    end
    lux = round_div(COS_Q30 * dx + SIN_Q30 * dy, len);
    luy = round_div(COS_Q30 * dy - SIN_Q30 * dx, len);
    rux = round_div(COS_Q30 * dx - SIN_Q30 * dy, len);
    ruy = round_div(COS_Q30 * dy + SIN_Q30 * dx, len);
    lux = round_div(lux * longint'(wing), 64'd1 << 30);
    luy = round_div(luy * longint'(wing), 64'd1 << 30);
    rux = round_div(rux * longint'(wing), 64'd1 << 30);
    ruy = round_div(ruy * longint'(wing), 64'd1 << 30);
    s = '{sx, sy, ex, ey, colour_model, 1'b0};
    pending_segs.push_back(s);
    s = '{ex, ey, clip32(longint'(ex) + lux), clip32(longint'(ey) + luy),
          colour_model, 1'b0};
    pending_segs.push_back(s);
    s = '{ex, ey, clip32(longint'(ex) + rux), clip32(longint'(ey) + ruy),
          colour_model, 1'b1};
    pending_segs.push_back(s);
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // offer one vector and wait for its transfer
  task automatic send_vector(logic signed [31:0] sx, logic signed [31:0] sy,
                             logic signed [31:0] ex, logic signed [31:0] ey,
                             bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_arrow(sx, sy, ex, ey);
    vec_count++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_colour(logic [31:0] c);
    cfg_write <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_write <= 1'b0;
    colour_model = c;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_gap <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      pop <= 1'b0;
    end else if (allow_stall && $urandom_range(0, 3) == 0) begin
      rx_gap <= gap_len();
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // check each popped segment
  always @(posedge clk) begin
    segment_t got, want;
    if (!rst && pop && !empty) begin
      got = '{seg_x0, seg_y0, seg_x1, seg_y1, seg_color, last_segment};
      seg_count++;
      if (pending_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %p", got);
      end else begin
        want = pending_segs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("segment %0d mismatch: expected %p actual %p", seg_count, want, got);
        end
      end
    end
  end

  // directed: extremes, zero length, saturation, clamp limits
  task automatic test_directed();
    send_vector(0, 0, 0, 0);
    send_vector(32'h00010000, 32'h00020000, 32'h00010000, 32'h00020000);
    send_vector(0, 0, 32'sh7fffffff, 32'sh7fffffff);
    send_vector(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_vector(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_vector(32'sh80000000, 0, 32'sh7fffffff, 0);
    send_vector(0, 32'sh7fffffff, 0, 32'sh80000000);
    send_vector(32'sh7fff0000, 0, 32'sh7fffff00, 0);
    send_vector(0, 0, 32'sh80000000, 1);
    send_vector(0, 0, 1, 0);
    send_vector(0, 0, 0, -1);
    send_vector(0, 0, 30 << 16, 0);
    send_vector(0, 0, 200 << 16, 0);
    send_vector(0, 0, 0, 3000 << 16);
    send_vector(100 << 16, -50 << 16, -100 << 16, 50 << 16);
    send_vector(32'hffffffff, 32'hffffffff, 0, 0);
    send_vector(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555);
    wait_drained();
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 65535)
                                     : 32'sh80000000 + $urandom_range(0, 65535);
      default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    endcase
  endfunction

  // random vectors, mostly near each other so every clamp region is hit
  task automatic test_random(int n);
    logic signed [31:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = rand_coord();
      sy = rand_coord();
      if ($urandom_range(0, 2) == 0)
        send_vector(sx, sy, rand_coord(), rand_coord());
      else
        send_vector(sx, sy, sx + ($signed($urandom_range(0, 1 << 25)) - (1 << 24)),
                    sy + ($signed($urandom_range(0, 1 << 25)) - (1 << 24)));
    end
  endtask

  // receiver holds off while the sender keeps pushing until input stalls
  task automatic test_backpressure();
    hold_off <= 3000;
    for (int i = 0; i < 12; i++)
      send_vector($urandom(), $urandom(), $urandom(), $urandom(), 0);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    cycles = 0;
    hold_off = 0;
    mismatches = 0;
    seg_count = 0;
    vec_count = 0;
    allow_stall = 0;
    colour_model = COLOR_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    write_colour(32'h00000000);
    allow_stall = 1;
    test_random(150);
    wait_drained();
    write_colour(32'hffffffff);
    test_backpressure();
    write_colour($urandom());
    test_random(150);
    wait_drained();
    write_colour(32'h12345678);
    test_random(150);

    wait_drained();
    $display("covered %0d vectors, %0d segments, five colour settings, long back-pressure",
             vec_count, seg_count);
    if (mismatches == 0 && pending_segs.size() == 0) begin
      $display("arrow_segment_generator regression: pass");
    end else begin
      $display("%0d mismatches, %0d segments outstanding", mismatches, pending_segs.size());
      $display("arrow_segment_generator regression: fail");
    end
    $finish;
  end

endmodule
